FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: concurrent assertion helpers for checker modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clk edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every clk edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/grf_pkg.sv
// ----------------------------------------------------------------------------
// grf_pkg
// Types, constants and helpers of the get reply framer.
// ----------------------------------------------------------------------------
`default_nettype none

package grf_pkg;

  localparam int LENGTH_BITS = 20;
  localparam int VLEN_W      = 20;
  localparam int TRAILER_LEN = 2;

  localparam logic [7:0] CHAR_V  = 8'h56;
  localparam logic [7:0] CHAR_SP = 8'h20;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_E  = 8'h45;
  localparam logic [7:0] CHAR_N  = 8'h4E;
  localparam logic [7:0] CHAR_D  = 8'h44;
  localparam logic [7:0] CHAR_0  = 8'h30;
  localparam logic [7:0] CHAR_9  = 8'h39;

  // matched length of "END" CR
  localparam logic [2:0] END_LEN    = 3'd4;
  localparam logic [1:0] SPACES_NUM = 2'd3;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_BODY   = 2'd1;
  localparam logic [1:0] KIND_LINE   = 2'd2;
  localparam logic [1:0] KIND_AFTER  = 2'd3;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_BAD_LINE  = 2'd1;
  localparam logic [1:0] ERR_AFTER_END = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_reply;
  } item_t;

  typedef struct packed {
    logic [1:0]        byte_kind;
    logic              length_valid;
    logic [VLEN_W-1:0] value_length;
    logic              reply_complete;
    logic [1:0]        fault_code;
  } result_t;

  function automatic logic [7:0] end_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = CHAR_E;
      2'd1:    c = CHAR_N;
      2'd2:    c = CHAR_D;
      default: c = CHAR_CR;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/grf_if.sv
// ----------------------------------------------------------------------------
// grf_if
// Valid/ready channels for reply bytes and per-byte results.
// ----------------------------------------------------------------------------
`default_nettype none

interface grf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_reply;

  modport source (output valid, output data_byte, output new_reply, input ready);
  modport sink   (input valid, input data_byte, input new_reply, output ready);
endinterface

interface grf_result_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 byte_kind;
  logic                       length_valid;
  logic [grf_pkg::VLEN_W-1:0] value_length;
  logic                       reply_complete;
  logic [1:0]                 fault_code;

  modport source (output valid, output byte_kind, output length_valid,
                  output value_length, output reply_complete, output fault_code,
                  input ready);
  modport sink   (input valid, input byte_kind, input length_valid,
                  input value_length, input reply_complete, input fault_code,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/grf_in_reg.sv
// ----------------------------------------------------------------------------
// grf_in_reg
// Input register: captures one request, frees up as the core drains it.
// ----------------------------------------------------------------------------
`default_nettype none

module grf_in_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           valid,
  output logic                ready,
  input  wire grf_pkg::item_t item,
  input  wire logic           drain,
  output logic                held,
  output grf_pkg::item_t      item_q
);

  assign ready = !held || drain;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (ready) begin
      held <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (valid && ready) begin
      item_q <= item;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/grf_core.sv
// ----------------------------------------------------------------------------
// grf_core
// Parser state and the per-byte update: classifies a byte, tracks the
// VALUE header length, skips body bytes and checks the END line.
// ----------------------------------------------------------------------------
`default_nettype none

module grf_core #(
  parameter int LENGTH_BITS = grf_pkg::LENGTH_BITS
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           fire,
  input  wire grf_pkg::item_t item,
  output grf_pkg::result_t    result
);

  localparam int SKIP_W = LENGTH_BITS + 1;
  localparam int PROD_W = LENGTH_BITS + 4;
  localparam int WIDE_W = LENGTH_BITS + grf_pkg::VLEN_W;

  typedef enum logic [2:0] {
    MODE_LINE_START,
    MODE_HEADER,
    MODE_SKIP,
    MODE_OTHER,
    MODE_DONE,
    MODE_DEAD
  } mode_t;

  mode_t                   mode, mode_next;
  logic [1:0]              space_count, space_count_next;
  logic                    number_active, number_active_next;
  logic [LENGTH_BITS-1:0]  length_acc, length_acc_next;
  logic [SKIP_W-1:0]       skip_remaining, skip_remaining_next;
  logic [2:0]              end_index, end_index_next;
  logic                    line_mismatch, line_mismatch_next;
  logic [1:0]              sticky_error, sticky_error_next;

  always_comb begin
    mode_t                  m;
    logic [1:0]             sc;
    logic                   num;
    logic [LENGTH_BITS-1:0] acc;
    logic [SKIP_W-1:0]      skip;
    logic [2:0]             emi;
    logic                   mism;
    logic [1:0]             err;
    logic [PROD_W-1:0]      prod;
    logic [WIDE_W-1:0]      wide;
    logic [7:0]             b;

    b    = item.data_byte;
    m    = mode;
    sc   = space_count;
    num  = number_active;
    acc  = length_acc;
    skip = skip_remaining;
    emi  = end_index;
    mism = line_mismatch;
    err  = sticky_error;
    prod = '0;
    wide = '0;
    result = '0;

    if (item.new_reply) begin
      m    = MODE_LINE_START;
      sc   = '0;
      num  = 1'b0;
      acc  = '0;
      skip = '0;
      emi  = '0;
      mism = 1'b0;
      err  = grf_pkg::ERR_NONE;
    end

    if (m == MODE_LINE_START && b == grf_pkg::CHAR_V) begin
      m   = MODE_HEADER;
      sc  = '0;
      num = 1'b0;
      acc = '0;
      result.byte_kind = grf_pkg::KIND_HEADER;
    end else begin
      // any other first byte opens a line that must read END
      if (m == MODE_LINE_START) begin
        m    = MODE_OTHER;
        emi  = '0;
        mism = 1'b0;
      end
      case (m)
        MODE_HEADER: begin
          result.byte_kind = grf_pkg::KIND_HEADER;
          if (b == grf_pkg::CHAR_LF) begin
            wide = {{grf_pkg::VLEN_W{1'b0}}, acc};
            result.length_valid = 1'b1;
            result.value_length = wide[grf_pkg::VLEN_W-1:0];
            skip = {1'b0, acc} + SKIP_W'(grf_pkg::TRAILER_LEN);
            m    = MODE_SKIP;
          end else if (b == grf_pkg::CHAR_SP) begin
            if (sc < grf_pkg::SPACES_NUM) begin
              sc  = sc + 2'd1;
              num = (sc == grf_pkg::SPACES_NUM);
            end else begin
              num = 1'b0;
            end
          end else if (b >= grf_pkg::CHAR_0 && b <= grf_pkg::CHAR_9 && num) begin
            // acc * 10 + digit, saturating
            prod = ({4'd0, acc} << 3) + ({4'd0, acc} << 1)
                 + {{LENGTH_BITS{1'b0}}, b[3:0]};
            if (prod > {4'd0, {LENGTH_BITS{1'b1}}}) begin
              acc = {LENGTH_BITS{1'b1}};
              err = grf_pkg::ERR_OVERFLOW;
            end else begin
              acc = prod[LENGTH_BITS-1:0];
            end
          end else begin
            num = 1'b0;
          end
        end
        MODE_SKIP: begin
          result.byte_kind = grf_pkg::KIND_BODY;
          if (skip != '0) begin
            skip = skip - SKIP_W'(1);
          end
          if (skip == '0) begin
            m = MODE_LINE_START;
          end
        end
        MODE_OTHER: begin
          result.byte_kind = grf_pkg::KIND_LINE;
          if (b == grf_pkg::CHAR_LF) begin
            if (!mism && emi == grf_pkg::END_LEN) begin
              result.reply_complete = 1'b1;
              m = MODE_DONE;
            end else begin
              err = grf_pkg::ERR_BAD_LINE;
              m   = MODE_DEAD;
            end
          end else begin
            if (emi >= grf_pkg::END_LEN || b != grf_pkg::end_char(emi[1:0])) begin
              mism = 1'b1;
            end
            if (emi < grf_pkg::END_LEN) begin
              emi = emi + 3'd1;
            end
          end
        end
        MODE_DONE: begin
          result.byte_kind = grf_pkg::KIND_AFTER;
          err = grf_pkg::ERR_AFTER_END;
        end
        default: begin
          result.byte_kind = grf_pkg::KIND_AFTER;
          m = MODE_DEAD;
        end
      endcase
    end

    result.fault_code = err;

    mode_next           = m;
    space_count_next    = sc;
    number_active_next  = num;
    length_acc_next     = acc;
    skip_remaining_next = skip;
    end_index_next      = emi;
    line_mismatch_next  = mism;
    sticky_error_next   = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_LINE_START;
      space_count    <= '0;
      number_active  <= 1'b0;
      length_acc     <= '0;
      skip_remaining <= '0;
      end_index      <= '0;
      line_mismatch  <= 1'b0;
      sticky_error   <= grf_pkg::ERR_NONE;
    end else if (fire) begin
      mode           <= mode_next;
      space_count    <= space_count_next;
      number_active  <= number_active_next;
      length_acc     <= length_acc_next;
      skip_remaining <= skip_remaining_next;
      end_index      <= end_index_next;
      line_mismatch  <= line_mismatch_next;
      sticky_error   <= sticky_error_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/grf_out_reg.sv
// ----------------------------------------------------------------------------
// grf_out_reg
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module grf_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire grf_pkg::result_t result,
  output logic                  space,
  output logic                  valid,
  input  wire logic             ready,
  output grf_pkg::result_t      result_q
);

  assign space = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (space) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && space) begin
      result_q <= result;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/get_reply_framer.sv
// an accepted byte is held in the input register, and its result in the result register before it is offered
// throughput: one byte per cycle while the result channel is ready; input register, parser update, result register
// the per-byte state update and multiply-by-ten accumulate are combinational between the two registers
// reset (rst, synchronous): parser back to line start, errors cleared, both
// registers empty
// ----------------------------------------------------------------------------
// get_reply_framer
// Byte-serial framer for a text get reply: one result per reply byte.
// ----------------------------------------------------------------------------
`default_nettype none

module get_reply_framer #(
  parameter int LENGTH_BITS = grf_pkg::LENGTH_BITS
) (
  input wire logic      clk,
  input wire logic      rst,
  grf_byte_if.sink      byte_ch,
  grf_result_if.source  result_ch
);

  grf_pkg::item_t   item_in, item_q;
  grf_pkg::result_t result, result_q;
  logic             held, space, fire;

  assign item_in.data_byte = byte_ch.data_byte;
  assign item_in.new_reply = byte_ch.new_reply;

  // core consumes the held byte whenever the result register can take it
  assign fire = held && space;

  grf_in_reg u_in_reg (
    .clk    (clk),
    .rst    (rst),
    .valid  (byte_ch.valid),
    .ready  (byte_ch.ready),
    .item   (item_in),
    .drain  (fire),
    .held   (held),
    .item_q (item_q)
  );

  grf_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (item_q),
    .result (result)
  );

  grf_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (held),
    .result   (result),
    .space    (space),
    .valid    (result_ch.valid),
    .ready    (result_ch.ready),
    .result_q (result_q)
  );

  assign result_ch.byte_kind      = result_q.byte_kind;
  assign result_ch.length_valid   = result_q.length_valid;
  assign result_ch.value_length   = result_q.value_length;
  assign result_ch.reply_complete = result_q.reply_complete;
  assign result_ch.fault_code     = result_q.fault_code;

endmodule

`default_nettype wire

FILE: rtl/grf_checker.sv
// ----------------------------------------------------------------------------
// grf_checker
// Port-level checks on the framer's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module grf_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [1:0]                 byte_kind,
  input wire logic                       length_valid,
  input wire logic [grf_pkg::VLEN_W-1:0] value_length,
  input wire logic                       reply_complete,
  input wire logic [1:0]                 fault_code
);

  logic                       stalled;
  logic                       kind_header;
  logic                       kind_line;
  logic [grf_pkg::VLEN_W+5:0] shown;

  assign stalled     = out_valid && !out_ready;
  assign kind_header = byte_kind == grf_pkg::KIND_HEADER;
  assign kind_line   = byte_kind == grf_pkg::KIND_LINE;
  assign shown       = {byte_kind, length_valid, value_length, reply_complete, fault_code};

  // a stalled result keeps its contents
  `ASSERT_CLK(a_stall_hold, stalled |=> out_valid && $stable(shown), "stalled result changed")

  `ASSERT_CLK(a_len_on_header, out_valid && length_valid |-> kind_header, "length off a header")

  `ASSERT_CLK(a_len_zero, out_valid && !length_valid |-> value_length == '0, "stray length")

  `ASSERT_CLK(a_complete_kind, out_valid && reply_complete |-> kind_line, "stray completion")

  `ASSERT_CLK_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid right after reset")

endmodule

bind get_reply_framer grf_checker u_grf_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (result_ch.valid),
  .out_ready      (result_ch.ready),
  .byte_kind      (result_ch.byte_kind),
  .length_valid   (result_ch.length_valid),
  .value_length   (result_ch.value_length),
  .reply_complete (result_ch.reply_complete),
  .fault_code     (result_ch.fault_code)
);

`default_nettype wire

FILE: sim/get_reply_framer_tb.sv
// ----------------------------------------------------------------------------
// get_reply_framer_tb
// Feeds reply byte streams into the get reply framer and checks every
// per-byte result against a cycle-free model of the parser kept in the bench.
// A short directed stream comes first, then random replies: mostly
// well-formed VALUE/END sequences with random content, plus corrupted lines,
// truncated bodies, bytes after END and noise. Both channels idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module get_reply_framer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_BYTES = 850;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned HOLD_AFTER   = 300;
  localparam int unsigned CALM_TAIL    = 100;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS  = 40;
  localparam int unsigned BODY_MAX     = 200;
  localparam int          LEN_BITS     = grf_pkg::LENGTH_BITS;

  localparam logic [63:0] LEN_MAX  = (64'd1 << LEN_BITS) - 64'd1;
  localparam logic [31:0] END_WORD = {grf_pkg::CHAR_E, grf_pkg::CHAR_N,
                                      grf_pkg::CHAR_D, grf_pkg::CHAR_CR};

  typedef enum logic [2:0] {
    P_LINE_START, P_HEADER, P_SKIP, P_OTHER, P_DONE, P_DEAD
  } parse_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  grf_byte_if   byte_ch ();
  grf_result_if result_ch ();

  get_reply_framer i_dut (
    .clk       (clk),
    .rst       (rst),
    .byte_ch   (byte_ch),
    .result_ch (result_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // reply bytes still to send, and per-byte results still owed by the block
  grf_pkg::item_t   tx_bytes[$];
  grf_pkg::result_t reply_results[$];

  // parser model state
  parse_mode_t         pmode;
  logic [1:0]          n_spaces;
  logic                digits_on;
  logic [LEN_BITS-1:0] acc;
  logic [LEN_BITS:0]   skip_left;
  logic [2:0]          end_idx;
  logic                line_bad;
  logic [1:0]          err;

  int unsigned bytes_in;
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          took_byte;
  bit          mark_start;
  bit          noise_on;
  bit          cut_short;

  int unsigned      src_gap, src_stretch, snk_gap, snk_stretch, hold_left;
  bit               src_idle_ok, snk_idle_ok, held_once;
  grf_pkg::result_t seen_result, due_result;

  function automatic void clear_parser();
    pmode     = P_LINE_START;
    n_spaces  = '0;
    digits_on = 1'b0;
    acc       = '0;
    skip_left = '0;
    end_idx   = '0;
    line_bad  = 1'b0;
    err       = grf_pkg::ERR_NONE;
  endfunction

  function automatic grf_pkg::result_t frame_byte(input logic [7:0] b, input logic fresh);
    grf_pkg::result_t r;
    logic [63:0]      grown;
    r = '0;
    if (fresh)
      clear_parser();
    if (pmode == P_LINE_START) begin
      if (b == grf_pkg::CHAR_V) begin
        pmode     = P_HEADER;
        n_spaces  = '0;
        digits_on = 1'b0;
        acc       = '0;
        r.byte_kind  = grf_pkg::KIND_HEADER;
        r.fault_code = err;
        return r;
      end
      pmode    = P_OTHER;
      end_idx  = '0;
      line_bad = 1'b0;
    end
    case (pmode)
      P_HEADER: begin
        r.byte_kind = grf_pkg::KIND_HEADER;
        if (b == grf_pkg::CHAR_LF) begin
          r.length_valid = 1'b1;
          r.value_length = grf_pkg::VLEN_W'(acc);
          skip_left      = {1'b0, acc} + (LEN_BITS+1)'(grf_pkg::TRAILER_LEN);
          pmode          = P_SKIP;
        end else if (b == grf_pkg::CHAR_SP) begin
          if (n_spaces < grf_pkg::SPACES_NUM) begin
            n_spaces  = n_spaces + 2'd1;
            digits_on = (n_spaces == grf_pkg::SPACES_NUM);
          end else begin
            digits_on = 1'b0;
          end
        end else if (b >= grf_pkg::CHAR_0 && b <= grf_pkg::CHAR_9 && digits_on) begin
          grown = 64'(acc) * 64'd10 + 64'(b - grf_pkg::CHAR_0);
          if (grown > LEN_MAX) begin
            grown = LEN_MAX;
            err   = grf_pkg::ERR_OVERFLOW;
          end
          acc = grown[LEN_BITS-1:0];
        end else begin
          digits_on = 1'b0;
        end
      end
      P_SKIP: begin
        r.byte_kind = grf_pkg::KIND_BODY;
        if (skip_left != 0)
          skip_left = skip_left - 1'b1;
        if (skip_left == 0)
          pmode = P_LINE_START;
      end
      P_OTHER: begin
        r.byte_kind = grf_pkg::KIND_LINE;
        if (b == grf_pkg::CHAR_LF) begin
          if (!line_bad && end_idx == grf_pkg::END_LEN) begin
            r.reply_complete = 1'b1;
            pmode            = P_DONE;
          end else begin
            err   = grf_pkg::ERR_BAD_LINE;
            pmode = P_DEAD;
          end
        end else begin
          if (end_idx >= grf_pkg::END_LEN ||
              b != END_WORD[31 - 8 * int'(end_idx[1:0]) -: 8])
            line_bad = 1'b1;
          if (end_idx < grf_pkg::END_LEN)
            end_idx = end_idx + 3'd1;
        end
      end
      P_DONE: begin
        r.byte_kind = grf_pkg::KIND_AFTER;
        err         = grf_pkg::ERR_AFTER_END;
      end
      default: begin
        r.byte_kind = grf_pkg::KIND_AFTER;
        pmode       = P_DEAD;
      end
    endcase
    r.fault_code = err;
    return r;
  endfunction

  // ---------------- stream generation ----------------

  function automatic void put(input logic [7:0] b);
    grf_pkg::item_t it;
    it.data_byte = b;
    it.new_reply = mark_start || (noise_on && $urandom_range(0, 99) == 0);
    mark_start   = 1'b0;
    tx_bytes.push_back(it);
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++)
      put(s[i]);
  endfunction

  function automatic void put_random(input int unsigned n);
    repeat (n)
      put(8'($urandom_range(0, 255)));
  endfunction

  function automatic string make_key();
    string k;
    k = "";
    repeat ($urandom_range(1, 6))
      k = {k, $sformatf("%c", $urandom_range(97, 122))};
    return k;
  endfunction

  function automatic void gen_value();
    int unsigned len, style, pick;
    string       num, eol, lead;
    pick = $urandom_range(0, 39);
    if (pick < 28)
      len = $urandom_range(0, 12);
    else if (pick < 37)
      len = $urandom_range(13, BODY_MAX);
    else if (pick < 38)
      len = 32'(LEN_MAX);
    else
      len = $urandom_range(32'(LEN_MAX) + 1, 2000000000);
    num   = $sformatf("%0d", len);
    style = $urandom_range(0, 9);
    eol   = "\r\n";
    lead  = "VALUE ";
    case (style)
      0: num = {num, " ", $sformatf("%0d", $urandom_range(0, 99))};
      1: num = {num, "x7"};
      2: num = {"00", num};
      3: begin
        num = "";
        len = 0;
      end
      4: eol = "\n";
      5: lead = "VALUE  ";
      default: ;
    endcase
    put_text({lead, make_key(), " ", $sformatf("%0d", $urandom_range(0, 65535)), " ",
              num, eol});
    // huge bodies are cut off; the next reply starts a fresh parse
    if (len > BODY_MAX) begin
      put_random($urandom_range(0, 20));
      cut_short = 1'b1;
    end else begin
      put_random(len);
      if ($urandom_range(0, 7) == 0)
        put_random(2);
      else
        put_text("\r\n");
    end
  endfunction

  function automatic void gen_end_line();
    case ($urandom_range(0, 19))
      14: put_text("EN\r\n");
      15: put_text("END\n");
      16: put_text("ENDX\r\n");
      17: put_text("END\r\r\n");
      18: begin
        put_random($urandom_range(1, 8));
        put_text("\n");
      end
      19: put_text("END\r");
      default: put_text("END\r\n");
    endcase
    if ($urandom_range(0, 4) == 0)
      put_random($urandom_range(1, 3));
  endfunction

  function automatic void gen_reply();
    int unsigned n;
    mark_start = 1'b1;
    cut_short  = 1'b0;
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1) == 0)
        put(grf_pkg::CHAR_V);
      put_random($urandom_range(1, 24));
      return;
    end
    n = $urandom_range(0, 3);
    repeat (n) begin
      gen_value();
      if (cut_short)
        return;
    end
    gen_end_line();
  endfunction

  function automatic bit near_end();
    return tx_bytes.size() < CALM_TAIL;
  endfunction

  // ---------------- request driver ----------------

  always @(negedge clk) begin
    if (rst) begin
      byte_ch.valid <= 1'b0;
    end else begin
      if (src_stretch == 0) begin
        src_stretch = $urandom_range(16, 96);
        src_idle_ok = $urandom_range(0, 2) != 0;
      end else begin
        src_stretch--;
      end
      // never drop a request that is still waiting for ready
      if (src_gap == 0 && src_idle_ok && !near_end() && !(byte_ch.valid && !took_byte) &&
          $urandom_range(0, 5) == 0)
        src_gap = $urandom_range(1, 18);
      if (src_gap != 0) begin
        src_gap--;
        byte_ch.valid <= 1'b0;
      end else if (tx_bytes.size() != 0) begin
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= tx_bytes[0].data_byte;
        byte_ch.new_reply <= tx_bytes[0].new_reply;
      end else begin
        byte_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------- result receiver ----------------

  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      result_ch.ready <= 1'b0;
    end else if (!held_once && bytes_in >= HOLD_AFTER) begin
      // long hold-off so the block backs up into the request side
      held_once = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      result_ch.ready <= 1'b0;
    end else begin
      if (snk_stretch == 0) begin
        snk_stretch = $urandom_range(16, 96);
        snk_idle_ok = $urandom_range(0, 2) != 0;
      end else begin
        snk_stretch--;
      end
      if (snk_gap == 0 && snk_idle_ok && !near_end() && $urandom_range(0, 5) == 0)
        snk_gap = $urandom_range(1, 18);
      if (snk_gap != 0) begin
        snk_gap--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------- prediction and checking ----------------

  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      took_byte = 1'b0;
    end else begin
      took_byte = byte_ch.valid && byte_ch.ready;
      if (took_byte) begin
        reply_results.push_back(frame_byte(byte_ch.data_byte, byte_ch.new_reply));
        void'(tx_bytes.pop_front());
        bytes_in++;
      end
      if (result_ch.valid && result_ch.ready) begin
        seen_result.byte_kind      = result_ch.byte_kind;
        seen_result.length_valid   = result_ch.length_valid;
        seen_result.value_length   = result_ch.value_length;
        seen_result.reply_complete = result_ch.reply_complete;
        seen_result.fault_code     = result_ch.fault_code;
        if (reply_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result: kind %0d lv %0d len %0d done %0d err %0d",
                     $time, seen_result.byte_kind, seen_result.length_valid,
                     seen_result.value_length, seen_result.reply_complete,
                     seen_result.fault_code);
        end else begin
          due_result = reply_results.pop_front();
          if (seen_result !== due_result) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display({"%0t: expected kind %0d lv %0d len %0d done %0d err %0d,",
                        " got kind %0d lv %0d len %0d done %0d err %0d"},
                       $time, due_result.byte_kind, due_result.length_valid,
                       due_result.value_length, due_result.reply_complete,
                       due_result.fault_code, seen_result.byte_kind,
                       seen_result.length_valid, seen_result.value_length,
                       seen_result.reply_complete, seen_result.fault_code);
          end
        end
      end
    end
  end

  // ---------------- run control ----------------

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("get_reply_framer: mismatch");
    $finish;
  end

  initial begin
    int unsigned directed_len;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    byte_ch.new_reply = 1'b0;
    result_ch.ready   = 1'b0;
    clear_parser();

    // overflowing length, cut short after two body bytes
    mark_start = 1'b1;
    put_text("V a b 1048576\n");
    put(8'h00);
    put(8'hFF);
    // clean end, then a byte after it
    mark_start = 1'b1;
    put_text("END\r\n");
    put(8'hFF);
    // empty line is a bad line, the reply is dead afterwards
    mark_start = 1'b1;
    put_text("\n");
    put(8'h80);
    // header with no number: zero length, only the trailer is skipped
    mark_start = 1'b1;
    put_text("V\n");
    put(8'h7F);
    put(8'h01);
    directed_len = tx_bytes.size();

    noise_on = 1'b1;
    while (tx_bytes.size() < directed_len + RANDOM_BYTES)
      gen_reply();

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    while (tx_bytes.size() != 0 || reply_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatches == 0 && reply_results.size() == 0)
      $display("get_reply_framer: match");
    else
      $display("get_reply_framer: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
